/* rtl/cst_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and character codes of the character stream tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int OUT_COORD_W = 16;
  localparam int MAX_EVENTS  = 4;

  typedef enum logic [1:0] {
    EV_APPEND  = 2'd0,
    EV_CLOSE   = 2'd1,
    EV_OPER    = 2'd2,
    EV_NOQUOTE = 2'd3
  } ev_kind_t;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    ev_kind_t               kind;
    logic [7:0]             ch;
    logic [OUT_COORD_W-1:0] line;
    logic [OUT_COORD_W-1:0] col;
    logic                   last;
  } ev_t;

  typedef struct packed {
    ev_t  [MAX_EVENTS-1:0] ev;
    logic [2:0]            count;
  } ev_batch_t;

  typedef struct packed {
    logic free;
    logic busy;
  } emit_status_t;

endpackage

`default_nettype wire

/* rtl/char_stream_tokenizer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// char_stream_tokenizer_top
// Byte-serial lexeme splitter: source bytes in, lexeme events out.
//
// Byte channel: byte_valid/byte_stall with source_byte and end_of_text. A byte
// is taken at an edge with byte_valid high and byte_stall low.
// Event channel: event_valid/event_stall with event_kind, event_char,
// line_number, column_number and run_last (high on the last event of a byte).
// A byte is held in the input register, then decoded into a batch of zero to
// four events that is loaded into the event buffer. Events leave one per cycle
// from the output register while event_stall is low; a byte keeps the buffer
// until its last event moves to the output register, so bytes with one or no
// event stream at one per cycle while event_stall is low.
// Reset clears line and column to 1, both flags and all valids.
// A stall on the event channel holds the output register; the buffer and the
// input register then fill and byte_stall rises.
// ----------------------------------------------------------------------------
module char_stream_tokenizer_top #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  source_byte,
  input  wire logic        end_of_text,
  output logic             event_valid,
  input  wire logic        event_stall,
  output logic [1:0]       event_kind,
  output logic [7:0]       event_char,
  output logic [15:0]      line_number,
  output logic [15:0]      column_number,
  output logic             run_last
);
  import cst_pkg::*;

  logic         byte_reg_valid;
  logic [7:0]   byte_reg;
  logic         eot_reg;
  logic         load;
  logic         accept;
  ev_batch_t    batch;
  emit_status_t emit_st;
  ev_t          event_data;

  assign load       = byte_reg_valid && emit_st.free;
  assign byte_stall = byte_reg_valid && !emit_st.free;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_reg_valid <= 1'b0;
    end else if (accept) begin
      byte_reg_valid <= 1'b1;
    end else if (load) begin
      byte_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_reg <= source_byte;
      eot_reg  <= end_of_text;
    end
  end

  cst_lexer #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_lexer (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .source_byte (byte_reg),
    .end_of_text (eot_reg),
    .batch       (batch)
  );

  cst_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .batch       (batch),
    .event_stall (event_stall),
    .status      (emit_st),
    .event_valid (event_valid),
    .event_data  (event_data)
  );

  assign event_kind    = event_data.kind;
  assign event_char    = event_data.ch;
  assign line_number   = event_data.line;
  assign column_number = event_data.col;
  assign run_last      = event_data.last;

  a_more_events_buffered: assert property (@(posedge clk) disable iff (rst)
    (event_valid && !run_last) |-> emit_st.busy)
    else $error("event without run_last but buffer empty");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> emit_st.busy)
    else $error("byte channel stalled with empty event buffer");

  a_load_needs_byte: assert property (@(posedge clk) disable iff (rst)
    (byte_reg_valid && !load) |=> byte_reg_valid)
    else $error("held byte dropped without decode");

endmodule

`default_nettype wire

/* rtl/cst_lexer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cst_lexer
// Scanner state (line, column, quote and lexeme flags) and the decode of one
// source byte into its batch of events.
// ----------------------------------------------------------------------------
module cst_lexer #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic [7:0]        source_byte,
  input  wire logic              end_of_text,
  output cst_pkg::ev_batch_t     batch
);
  import cst_pkg::*;

  localparam logic [COORD_WIDTH-1:0] COORD_MAX = '1;
  localparam logic [COORD_WIDTH-1:0] COORD_ONE = COORD_WIDTH'(1);

  logic [COORD_WIDTH-1:0] line_count;
  logic [COORD_WIDTH-1:0] column_count;
  logic                   inside_quotes;
  logic                   lexeme_pending;

  logic [COORD_WIDTH-1:0] line_count_next;
  logic [COORD_WIDTH-1:0] column_count_next;
  logic                   inside_quotes_next;
  logic                   lexeme_pending_next;

  function automatic logic [OUT_COORD_W-1:0] to_out(input logic [COORD_WIDTH-1:0] x);
    logic [COORD_WIDTH+OUT_COORD_W-1:0] ext;
    ext = {{OUT_COORD_W{1'b0}}, x};
    return ext[OUT_COORD_W-1:0];
  endfunction

  function automatic logic [COORD_WIDTH-1:0] sat_inc(input logic [COORD_WIDTH-1:0] x);
    return (x == COORD_MAX) ? x : x + COORD_ONE;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] minus_one(input logic [COORD_WIDTH-1:0] x);
    return (x == '0) ? '0 : x - COORD_ONE;
  endfunction

  function automatic ev_t mk_ev(input ev_kind_t k, input logic [7:0] ch,
                                input logic [COORD_WIDTH-1:0] l,
                                input logic [COORD_WIDTH-1:0] c);
    ev_t e;
    e.kind = k;
    e.ch   = ch;
    e.line = to_out(l);
    e.col  = to_out(c);
    e.last = 1'b0;
    return e;
  endfunction

  logic                   is_op;
  logic [COORD_WIDTH-1:0] l;
  logic [COORD_WIDTH-1:0] c;
  logic                   q;
  logic                   p;
  logic [2:0]             n;
  logic [2:0]             n_m1;
  ev_t  [MAX_EVENTS-1:0]  ev;

  always_comb begin
    case (source_byte) inside
      CH_PLUS, CH_MINUS, CH_EQUAL, CH_SEMI, CH_LPAREN, CH_RPAREN: is_op = 1'b1;
      default: is_op = 1'b0;
    endcase
  end

  always_comb begin
    l  = line_count;
    c  = column_count;
    q  = inside_quotes;
    p  = lexeme_pending;
    n  = 3'd0;
    ev = '0;
    if (q && source_byte != CH_QUOTE) begin
      ev[n[1:0]] = mk_ev(EV_APPEND, source_byte, l, c);
      n = n + 3'd1;
      c = sat_inc(c);
    end else if (source_byte == CH_QUOTE) begin
      if (q) begin
        ev[n[1:0]] = mk_ev(EV_APPEND, source_byte, l, c);
        n = n + 3'd1;
        ev[n[1:0]] = mk_ev(EV_CLOSE, 8'h00, l, minus_one(c));
        n = n + 3'd1;
        q = 1'b0;
        p = 1'b0;
      end else begin
        if (p) begin
          ev[n[1:0]] = mk_ev(EV_CLOSE, 8'h00, l, minus_one(c));
          n = n + 3'd1;
        end
        ev[n[1:0]] = mk_ev(EV_APPEND, source_byte, l, c);
        n = n + 3'd1;
        q = 1'b1;
        p = 1'b1;
      end
      c = sat_inc(c);
    end else if (source_byte == CH_NL) begin
      l = sat_inc(l);
      c = COORD_ONE;
    end else if (is_op) begin
      if (p) begin
        ev[n[1:0]] = mk_ev(EV_CLOSE, 8'h00, l, minus_one(c));
        n = n + 3'd1;
      end
      p = 1'b0;
      ev[n[1:0]] = mk_ev(EV_OPER, source_byte, l, c);
      n = n + 3'd1;
      c = sat_inc(c);
    end else if (source_byte == CH_SPACE) begin
      if (p) begin
        ev[n[1:0]] = mk_ev(EV_CLOSE, 8'h00, l, minus_one(c));
        n = n + 3'd1;
      end
      p = 1'b0;
      c = sat_inc(c);
    end else if (source_byte != CH_CR) begin
      ev[n[1:0]] = mk_ev(EV_APPEND, source_byte, l, c);
      n = n + 3'd1;
      p = 1'b1;
      c = sat_inc(c);
    end

    if (end_of_text) begin
      if (q) begin
        ev[n[1:0]] = mk_ev(EV_NOQUOTE, 8'h00, l, c);
        n = n + 3'd1;
      end
      if (p) begin
        ev[n[1:0]] = mk_ev(EV_CLOSE, 8'h00, l, minus_one(c));
        n = n + 3'd1;
      end
      l = COORD_ONE;
      c = COORD_ONE;
      q = 1'b0;
      p = 1'b0;
    end

    n_m1 = n - 3'd1;
    if (n != 3'd0) begin
      ev[n_m1[1:0]].last = 1'b1;
    end

    line_count_next     = l;
    column_count_next   = c;
    inside_quotes_next  = q;
    lexeme_pending_next = p;
    batch.ev            = ev;
    batch.count         = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count     <= COORD_ONE;
      column_count   <= COORD_ONE;
      inside_quotes  <= 1'b0;
      lexeme_pending <= 1'b0;
    end else if (load) begin
      line_count     <= line_count_next;
      column_count   <= column_count_next;
      inside_quotes  <= inside_quotes_next;
      lexeme_pending <= lexeme_pending_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/cst_emit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cst_emit
// Event buffer for one byte's batch and the output register that hands the
// events out one per transfer.
// ----------------------------------------------------------------------------
module cst_emit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire cst_pkg::ev_batch_t   batch,
  input  wire logic                 event_stall,
  output cst_pkg::emit_status_t     status,
  output logic                      event_valid,
  output cst_pkg::ev_t              event_data
);
  import cst_pkg::*;

  ev_t  [MAX_EVENTS-1:0] buf_ev;
  logic [2:0]            buf_cnt;
  logic [1:0]            buf_idx;

  logic out_ready;
  logic pop;

  assign out_ready   = !event_valid || !event_stall;
  assign pop         = (buf_cnt != 3'd0) && out_ready;
  assign status.busy = (buf_cnt != 3'd0);
  assign status.free = (buf_cnt == 3'd0) || ((buf_cnt == 3'd1) && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= 3'd0;
      buf_idx <= 2'd0;
    end else if (load) begin
      buf_cnt <= batch.count;
      buf_idx <= 2'd0;
    end else if (pop) begin
      buf_cnt <= buf_cnt - 3'd1;
      buf_idx <= buf_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_ev <= batch.ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (out_ready) begin
      event_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      event_data <= buf_ev[buf_idx];
    end
  end

endmodule

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the character stream tokenizer. Source text goes in
// one byte per transfer. A scoreboard tracks line, column, quote and lexeme
// state, predicts the lexeme events of every accepted byte, and compares each
// event transfer field by field. Stimulus starts with directed cases. Random
// source text follows, together with raw byte noise, under phases of sender
// gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 90;
  localparam logic [15:0] COORD_TOP = 16'hFFFF;

  class cst_scoreboard;
    ev_t         expected_q[$];
    logic [15:0] line_cnt;
    logic [15:0] col_cnt;
    bit          in_quotes;
    bit          pending;
    int          errors;
    int          events_seen;

    function new();
      restart();
      errors = 0;
      events_seen = 0;
    endfunction

    function void restart();
      line_cnt = 16'd1;
      col_cnt = 16'd1;
      in_quotes = 1'b0;
      pending = 1'b0;
    endfunction

    function void push_event(ev_kind_t k, logic [7:0] c, logic [15:0] col);
      ev_t e;
      e.kind = k;
      e.ch = c;
      e.line = line_cnt;
      e.col = col;
      e.last = 1'b0;
      expected_q = {expected_q, e};
    endfunction

    function void close_lexeme();
      if (pending) push_event(EV_CLOSE, 8'h00, (col_cnt == 0) ? 16'd0 : col_cnt - 16'd1);
      pending = 1'b0;
    endfunction

    function void bump_col();
      if (col_cnt != COORD_TOP) col_cnt = col_cnt + 16'd1;
    endfunction

    function void note_byte(logic [7:0] c, logic eot);
      int n0;
      n0 = expected_q.size();
      if (in_quotes && c != CH_QUOTE) begin
        push_event(EV_APPEND, c, col_cnt);
        bump_col();
      end else if (c == CH_QUOTE) begin
        if (in_quotes) begin
          push_event(EV_APPEND, c, col_cnt);
          push_event(EV_CLOSE, 8'h00, (col_cnt == 0) ? 16'd0 : col_cnt - 16'd1);
          in_quotes = 1'b0;
          pending = 1'b0;
        end else begin
          close_lexeme();
          push_event(EV_APPEND, c, col_cnt);
          in_quotes = 1'b1;
          pending = 1'b1;
        end
        bump_col();
      end else if (c == CH_NL) begin
        if (line_cnt != COORD_TOP) line_cnt = line_cnt + 16'd1;
        col_cnt = 16'd1;
      end else if (c inside {CH_PLUS, CH_MINUS, CH_EQUAL, CH_SEMI, CH_LPAREN, CH_RPAREN}) begin
        close_lexeme();
        push_event(EV_OPER, c, col_cnt);
        bump_col();
      end else if (c == CH_SPACE) begin
        close_lexeme();
        bump_col();
      end else if (c != CH_CR) begin
        push_event(EV_APPEND, c, col_cnt);
        pending = 1'b1;
        bump_col();
      end
      if (eot) begin
        if (in_quotes) push_event(EV_NOQUOTE, 8'h00, col_cnt);
        close_lexeme();
        restart();
      end
      if (expected_q.size() > n0) expected_q[expected_q.size()-1].last = 1'b1;
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      if (errors <= 20)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_event(ev_t got);
      ev_t want;
      events_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: unexpected event, expected none, actual kind %0d char %0d line %0d col %0d",
                   $time, got.kind, got.ch, got.line, got.col);
        return;
      end
      want = expected_q.pop_front();
      if (got.kind != want.kind) report("event_kind", want.kind, got.kind);
      if (got.ch != want.ch) report("event_char", want.ch, got.ch);
      if (got.line != want.line) report("line_number", want.line, got.line);
      if (got.col != want.col) report("column_number", want.col, got.col);
      if (got.last != want.last) report("run_last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  source_byte = 8'h00;
  logic        end_of_text = 1'b0;
  logic        event_valid;
  logic        event_stall = 1'b0;
  logic [1:0]  event_kind;
  logic [7:0]  event_char;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic        run_last;

  cst_scoreboard model;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          bytes_sent = 0;
  int          cycle_count = 0;
  logic [7:0]  text_q[$];
  logic [7:0]  op_set[6] = '{CH_PLUS, CH_MINUS, CH_EQUAL, CH_SEMI, CH_LPAREN, CH_RPAREN};
  int          idle_tab[4] = '{0, 66, 0, 24};
  int          stall_tab[4] = '{0, 0, 66, 24};

  char_stream_tokenizer_top uut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .source_byte  (source_byte),
    .end_of_text  (end_of_text),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_kind   (event_kind),
    .event_char   (event_char),
    .line_number  (line_number),
    .column_number(column_number),
    .run_last     (run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still expected",
               cycle_count, model.expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    ev_t got;
    if (rst) begin
      event_stall <= 1'b0;
    end else begin
      if (event_valid && !event_stall) begin
        got.kind = ev_kind_t'(event_kind);
        got.ch = event_char;
        got.line = line_number;
        got.col = column_number;
        got.last = run_last;
        model.check_event(got);
      end
      event_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      byte_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    byte_valid <= 1'b1;
    source_byte <= b;
    end_of_text <= eot;
    do @(posedge clk); while (byte_stall);
    model.note_byte(b, eot);
    bytes_sent++;
  endtask

  task automatic send_str(input string s, input bit eot);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(3))
      0: return 8'($urandom_range(97, 122));
      1: return 8'($urandom_range(65, 90));
      2: return 8'($urandom_range(48, 57));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  task automatic build_source(input int tokens);
    logic [7:0] c;
    text_q.delete();
    for (int t = 0; t < tokens; t++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: repeat ($urandom_range(1, 6)) text_q = {text_q, word_char()};
        4: text_q = {text_q, op_set[$urandom_range(5)]};
        5, 8: repeat ($urandom_range(1, 2)) text_q = {text_q, CH_SPACE};
        6: begin
          if ($urandom_range(1)) text_q = {text_q, CH_CR};
          text_q = {text_q, CH_NL};
        end
        7: begin
          text_q = {text_q, CH_QUOTE};
          repeat ($urandom_range(0, 5)) begin
            do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
            text_q = {text_q, c};
          end
          if (t != tokens - 1 || $urandom_range(1)) text_q = {text_q, CH_QUOTE};
        end
        default: text_q = {text_q, CH_CR};
      endcase
    end
  endtask

  task automatic send_source();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  initial begin
    int phase_start;
    model = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed cases
    send_str("x", 1'b1);
    send_str("a+-=;() ", 1'b0);
    send_str("k\nm", 1'b1);
    send_str("\"p\n", 1'b0);
    send_byte(CH_CR, 1'b0);
    send_str(" q\"", 1'b1);
    send_str("ab\"", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_SPACE, 1'b1);
    send_byte(CH_NL, 1'b1);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_tab[p];
      stall_pct = stall_tab[p];
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(9) < 8) begin
          build_source($urandom_range(2, 10));
          send_source();
        end else begin
          repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        end
      end
    end

    byte_valid <= 1'b0;
    while (model.expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("sent %0d bytes (directed, random text and noise), checked %0d events",
             bytes_sent, model.events_seen);
    $display("idle phases: none, sender gaps, receiver stalls, both; %0d mismatches",
             model.errors);
    if (model.errors == 0 && model.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cst_pkg.sv
rtl/cst_lexer.sv
rtl/cst_emit.sv
rtl/char_stream_tokenizer_top.sv
sim/tb.sv
